// File: rtl/bpim_pkg.sv
// ----------------------------------------------------------------------------
// bpim_pkg
// Shared constants, register codes and helpers of the 3D block partition
// index mapper.
// ----------------------------------------------------------------------------
package bpim_pkg;

    // Default widths of the index datapath and of the grid extent registers.
    localparam int INDEX_BITS_DEF = 42;
    localparam int DIM_BITS_DEF   = 14;

    // Fixed register widths.
    localparam int PROCS_W   = 11;
    localparam int RANK_W    = 20;
    localparam int CFG_IDX_W = 3;

    // Width of one multiplier slice in the multiply-add pipeline.
    localparam int MUL_CHUNK = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_X   = 3'd0,
        REG_DIM_Y   = 3'd1,
        REG_DIM_Z   = 3'd2,
        REG_BLOCK   = 3'd3,
        REG_PROCS_X = 3'd4,
        REG_PROCS_Y = 3'd5,
        REG_RANK    = 3'd6,
        REG_PART_OK = 3'd7
    } t_cfg_reg;

    // Larger of two elaboration-time integers.
    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/bpim_req_if.sv
// ----------------------------------------------------------------------------
// bpim_req_if
// Request channel: a request type and the row index to convert.
// ----------------------------------------------------------------------------
interface bpim_req_if #(
    parameter int INDEX_BITS = bpim_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [INDEX_BITS-1:0] index;

    modport source (output valid, req_type, index, input ready);
    modport sink   (input valid, req_type, index, output ready);
endinterface

// File: rtl/bpim_rsp_if.sv
// ----------------------------------------------------------------------------
// bpim_rsp_if
// Response channel: the converted row index.
// ----------------------------------------------------------------------------
interface bpim_rsp_if #(
    parameter int INDEX_BITS = bpim_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] mapped_index;

    modport source (output valid, mapped_index, input ready);
    modport sink   (input valid, mapped_index, output ready);
endinterface

// File: rtl/block_partition_index_map_3d.sv
// ----------------------------------------------------------------------------
// block_partition_index_map_3d
// Maps grid row indices between lexicographic and per-subdomain numbering.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (req_type 0 forward, 1 inverse, plus the index)
// and each gives exactly one item on o_rsp, in order. The user must write
// registers on the plain i_cfg_* port only while no item is in flight; the
// block itself does not enforce this. Throughput is one item per cycle while
// the skid entry is empty and the sequencer is idle. The path runs through
// the three one-bit-per-stage index dividers, the two coordinate dividers
// and five sliced multiply-add pipelines.
// After reset and after every register write a serial sequencer derives the
// block volume, the rank offset and the rank origin, and i_req.ready stays
// low while it runs. Reset loads the register defaults (passthrough).
// When o_rsp stalls, an output register and one skid entry hold results;
// once the skid entry fills the whole pipeline freezes, losing nothing.
// ----------------------------------------------------------------------------
module block_partition_index_map_3d #(
    parameter int INDEX_BITS = bpim_pkg::INDEX_BITS_DEF,
    parameter int DIM_BITS   = bpim_pkg::DIM_BITS_DEF
) (
    input  logic                                                          i_clk,
    input  logic                                                          i_rst_n,
    bpim_req_if.sink                                                      i_req,
    bpim_rsp_if.source                                                    o_rsp,
    input  logic                                                          i_cfg_we,
    input  logic [bpim_pkg::CFG_IDX_W-1:0]                                i_cfg_idx,
    input  logic [bpim_pkg::max_int(DIM_BITS+1, bpim_pkg::RANK_W)-1:0]   i_cfg_data
);
    import bpim_pkg::*;

    localparam int W  = INDEX_BITS;
    localparam int DW = DIM_BITS + 1;

    typedef struct packed {
        logic          inv;
        logic [W-1:0]  idx;
        logic [DW-1:0] ra;
        logic [DW-1:0] rb;
        logic [W-1:0]  qc;
        logic [DW-1:0] rc;
        logic [DW-1:0] cxq;
        logic [DW-1:0] cxr;
    } t_dside;

    typedef struct packed {
        logic         inv;
        logic [W-1:0] idx;
        logic [W-1:0] s0;
        logic [W-1:0] s1;
        logic [W-1:0] s2;
        logic [W-1:0] s3;
    } t_mside;

    // Configuration and derived values.
    logic [DW-1:0]      dim_x, dim_y, dim_z, blk;
    logic [PROCS_W-1:0] procs_x, procs_y;
    logic               part_ok, busy, usable;
    logic [W-1:0]       b3, roff, rxb, ryb, rzb;

    bpim_cfg #(
        .W     (W),
        .DIM_W (DW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dim_x    (dim_x),
        .o_dim_y    (dim_y),
        .o_dim_z    (dim_z),
        .o_block    (blk),
        .o_procs_x  (procs_x),
        .o_procs_y  (procs_y),
        .o_part_ok  (part_ok),
        .o_b3       (b3),
        .o_roff     (roff),
        .o_rxb      (rxb),
        .o_ryb      (ryb),
        .o_rzb      (rzb),
        .o_busy     (busy)
    );

    assign usable = part_ok && (dim_x != '0) && (dim_y != '0) && (dim_z != '0) &&
                    (blk != '0) && (procs_x != '0) && (procs_y != '0);

    // The whole pipeline advances unless the skid entry is occupied.
    logic en;
    logic r_skid_v, r_out_v;
    assign en          = !r_skid_v;
    assign i_req.ready = en && !busy;

    // Input stage: an inverse index first drops this rank's offset.
    logic         r0_v;
    logic [W-1:0] r0_num;
    logic [DW-1:0] r0_den;
    t_dside       r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_req.valid && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_num       <= i_req.req_type ? (i_req.index - roff) : i_req.index;
            r0_den       <= i_req.req_type ? blk : dim_x;
            r0_side.inv  <= i_req.req_type;
            r0_side.idx  <= i_req.index;
            r0_side.ra   <= '0;
            r0_side.rb   <= '0;
            r0_side.qc   <= '0;
            r0_side.rc   <= '0;
            r0_side.cxq  <= '0;
            r0_side.cxr  <= '0;
        end
    end

    // First divider: x coordinate, or local x of an inverse item.
    logic          a_v;
    logic [W-1:0]  a_q;
    logic [DW-1:0] a_r;
    t_dside        a_side;

    bpim_div_pipe #(.NUM_W(W), .DEN_W(DW), .SIDE_W($bits(t_dside))) u_div_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (r0_v), .i_num (r0_num), .i_den (r0_den), .i_side (r0_side),
        .o_valid (a_v), .o_quo (a_q), .o_rem (a_r), .o_side (a_side)
    );

    // Second divider: y and z, or local y of an inverse item.
    logic          b_v;
    logic [W-1:0]  b_q;
    logic [DW-1:0] b_r;
    t_dside        b_in_side, b_side;
    logic [DW-1:0] b_den;

    always_comb begin
        b_in_side    = a_side;
        b_in_side.ra = a_r;
        b_den        = a_side.inv ? blk : dim_y;
    end

    bpim_div_pipe #(.NUM_W(W), .DEN_W(DW), .SIDE_W($bits(t_dside))) u_div_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (a_v), .i_num (a_q), .i_den (b_den), .i_side (b_in_side),
        .o_valid (b_v), .o_quo (b_q), .o_rem (b_r), .o_side (b_side)
    );

    // Third divider: block z and local z.
    logic          c_v;
    logic [W-1:0]  c_q;
    logic [DW-1:0] c_r;
    t_dside        c_in_side, c_side;

    always_comb begin
        c_in_side    = b_side;
        c_in_side.rb = b_r;
    end

    bpim_div_pipe #(.NUM_W(W), .DEN_W(DW), .SIDE_W($bits(t_dside))) u_div_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (b_v), .i_num (b_q), .i_den (blk), .i_side (c_in_side),
        .o_valid (c_v), .o_quo (c_q), .o_rem (c_r), .o_side (c_side)
    );

    // Coordinate dividers: block and local position along x, then y.
    logic          d1_v, d2_v;
    logic [DW-1:0] d1_q, d1_r, d2_q, d2_r;
    t_dside        d1_in_side, d1_side, d2_in_side, d2_side;

    always_comb begin
        d1_in_side    = c_side;
        d1_in_side.qc = c_q;
        d1_in_side.rc = c_r;
    end

    bpim_div_pipe #(.NUM_W(DW), .DEN_W(DW), .SIDE_W($bits(t_dside))) u_div_d1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (c_v), .i_num (c_side.ra), .i_den (blk), .i_side (d1_in_side),
        .o_valid (d1_v), .o_quo (d1_q), .o_rem (d1_r), .o_side (d1_side)
    );

    always_comb begin
        d2_in_side     = d1_side;
        d2_in_side.cxq = d1_q;
        d2_in_side.cxr = d1_r;
    end

    bpim_div_pipe #(.NUM_W(DW), .DEN_W(DW), .SIDE_W($bits(t_dside))) u_div_d2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (d1_v), .i_num (d1_side.rb), .i_den (blk), .i_side (d2_in_side),
        .o_valid (d2_v), .o_quo (d2_q), .o_rem (d2_r), .o_side (d2_side)
    );

    // Operand stage ahead of the multiply-add chain. A forward item starts
    // on its block coordinates; an inverse item on its global coordinates.
    logic         rp_v;
    logic [W-1:0] rp_a, rp_m, rp_c;
    t_mside       rp_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_v <= 1'b0;
        end else if (en) begin
            rp_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp_side.inv <= d2_side.inv;
            rp_side.idx <= d2_side.idx;
            if (d2_side.inv) begin
                rp_a       <= rzb + W'(d2_side.rc);
                rp_m       <= W'(dim_y);
                rp_c       <= ryb + W'(d2_side.rb);
                rp_side.s0 <= rxb + W'(d2_side.ra);
                rp_side.s1 <= '0;
                rp_side.s2 <= '0;
                rp_side.s3 <= '0;
            end else begin
                rp_a       <= d2_side.qc;
                rp_m       <= W'(procs_y);
                rp_c       <= W'(d2_q);
                rp_side.s0 <= W'(d2_side.rc);
                rp_side.s1 <= W'(d2_r);
                rp_side.s2 <= W'(d2_side.cxr);
                rp_side.s3 <= W'(d2_side.cxq);
            end
        end
    end

    // Multiply-add chain.
    logic         m1_v, m2_v, m3_v, m4_v, m5_v;
    logic [W-1:0] m1_res, m2_res, m3_res, m4_res, m5_res;
    t_mside       m1_side, m2_side, m3_side, m4_side, m5_side, m3_in_side;
    logic [W-1:0] m2_a, m2_m, m2_c, m3_a, m3_m, m3_c;
    logic [W-1:0] m4_a, m4_m, m4_c, m5_a, m5_m, m5_c;

    bpim_madd_pipe #(.W(W), .SIDE_W($bits(t_mside))) u_madd_1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (rp_v),
        .i_a (rp_a), .i_m (rp_m), .i_c (rp_c), .i_side (rp_side),
        .o_valid (m1_v), .o_res (m1_res), .o_side (m1_side)
    );

    // Forward: z-y block number times procs_x plus block x. Inverse: times dim_x plus x.
    always_comb begin
        m2_a = m1_res;
        m2_m = m1_side.inv ? W'(dim_x) : W'(procs_x);
        m2_c = m1_side.inv ? m1_side.s0 : m1_side.s3;
    end

    bpim_madd_pipe #(.W(W), .SIDE_W($bits(t_mside))) u_madd_2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (m1_v),
        .i_a (m2_a), .i_m (m2_m), .i_c (m2_c), .i_side (m1_side),
        .o_valid (m2_v), .o_res (m2_res), .o_side (m2_side)
    );

    // Forward items now build the local index; inverse items are finished.
    always_comb begin
        m3_in_side = m2_side;
        if (m2_side.inv) begin
            m3_a = m2_res;
            m3_m = W'(1);
            m3_c = '0;
        end else begin
            m3_a          = m2_side.s0;
            m3_m          = W'(blk);
            m3_c          = m2_side.s1;
            m3_in_side.s0 = m2_res;
        end
    end

    bpim_madd_pipe #(.W(W), .SIDE_W($bits(t_mside))) u_madd_3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (m2_v),
        .i_a (m3_a), .i_m (m3_m), .i_c (m3_c), .i_side (m3_in_side),
        .o_valid (m3_v), .o_res (m3_res), .o_side (m3_side)
    );

    always_comb begin
        m4_a = m3_res;
        m4_m = m3_side.inv ? W'(1) : W'(blk);
        m4_c = m3_side.inv ? '0 : m3_side.s2;
    end

    bpim_madd_pipe #(.W(W), .SIDE_W($bits(t_mside))) u_madd_4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (m3_v),
        .i_a (m4_a), .i_m (m4_m), .i_c (m4_c), .i_side (m3_side),
        .o_valid (m4_v), .o_res (m4_res), .o_side (m4_side)
    );

    // Forward: subdomain number times the block volume plus the local index.
    always_comb begin
        m5_a = m4_side.inv ? m4_res : m4_side.s0;
        m5_m = m4_side.inv ? W'(1) : b3;
        m5_c = m4_side.inv ? '0 : m4_res;
    end

    bpim_madd_pipe #(.W(W), .SIDE_W($bits(t_mside))) u_madd_5 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (m4_v),
        .i_a (m5_a), .i_m (m5_m), .i_c (m5_c), .i_side (m4_side),
        .o_valid (m5_v), .o_res (m5_res), .o_side (m5_side)
    );

    // Output register with one skid entry behind it.
    logic [W-1:0] p_res;
    logic [W-1:0] r_out, r_skid;
    logic         pop;

    assign p_res = usable ? m5_res : m5_side.idx;
    assign pop   = r_out_v && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (m5_v) begin
                if (!r_out_v || pop) begin
                    r_out   <= p_res;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= p_res;
                    r_skid_v <= 1'b1;
                end
            end else if (pop) begin
                r_out_v <= 1'b0;
            end
        end else if (pop) begin
            r_out    <= r_skid;
            r_skid_v <= 1'b0;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.mapped_index = r_out;

    // The skid entry only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds an item with no result in the output register");

    // Draining the skid entry leaves its item on the output.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_rsp.ready) |=> (r_out_v && !r_skid_v))
        else $error("skid entry drained without moving its item to the output");

    // A register write makes the derived values stale until recomputed.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (busy && !i_req.ready))
        else $error("request accepted before derived configuration settled");

endmodule

// File: rtl/bpim_div_pipe.sv
// ----------------------------------------------------------------------------
// bpim_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels alongside each item.
// ----------------------------------------------------------------------------
module bpim_div_pipe #(
    parameter int NUM_W  = 42,
    parameter int DEN_W  = 15,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [NUM_W];
    logic [NUM_W-1:0]  r_w    [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              pv;
        logic [NUM_W-1:0]  pw;
        logic [DEN_W-1:0]  prem;
        logic [DEN_W-1:0]  pden;
        logic [SIDE_W-1:0] pside;
        logic [DEN_W:0]    trial;
        logic              ge;

        // The first stage starts from the raw numerator and a zero remainder.
        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pw    = i_num;
            assign prem  = '0;
            assign pden  = i_den;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pw    = r_w[k-1];
            assign prem  = r_rem[k-1];
            assign pden  = r_den[k-1];
            assign pside = r_side[k-1];
        end

        // Bring down the next numerator bit and try a subtraction.
        assign trial = {prem, pw[NUM_W-1]};
        assign ge    = (trial >= {1'b0, pden});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        // Quotient bits fill in from the right as numerator bits leave.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DEN_W'(trial - {1'b0, pden}) : trial[DEN_W-1:0];
                r_w[k]    <= {pw[NUM_W-2:0], ge};
                r_den[k]  <= pden;
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_w[NUM_W-1];
    assign o_rem   = r_rem[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// File: rtl/bpim_madd_pipe.sv
// ----------------------------------------------------------------------------
// bpim_madd_pipe
// Pipelined multiply-add a * m + c modulo 2^W, one multiplier slice per
// stage, with a sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
module bpim_madd_pipe #(
    parameter int W      = 42,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_m,
    input  logic [W-1:0]      i_c,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_res,
    output logic [SIDE_W-1:0] o_side
);
    import bpim_pkg::*;

    localparam int NCH  = (W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MP_W = NCH * MUL_CHUNK;

    logic              r_v    [NCH];
    logic [W-1:0]      r_a    [NCH];
    logic [MP_W-1:0]   r_m    [NCH];
    logic [W-1:0]      r_acc  [NCH];
    logic [SIDE_W-1:0] r_side [NCH];

    for (genvar k = 0; k < NCH; k++) begin : g_stage
        logic                   pv;
        logic [W-1:0]           pa;
        logic [MP_W-1:0]        pm;
        logic [W-1:0]           pacc;
        logic [SIDE_W-1:0]      pside;
        logic [W+MUL_CHUNK-1:0] prod;
        logic [W+MUL_CHUNK-1:0] shifted;

        // The accumulator starts from the addend.
        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pa    = i_a;
            assign pm    = MP_W'(i_m);
            assign pacc  = i_c;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pa    = r_a[k-1];
            assign pm    = r_m[k-1];
            assign pacc  = r_acc[k-1];
            assign pside = r_side[k-1];
        end

        // One slice of the multiplier, weighted by its position.
        assign prod    = pa * pm[k*MUL_CHUNK +: MUL_CHUNK];
        assign shifted = prod << (k * MUL_CHUNK);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]    <= pa;
                r_m[k]    <= pm;
                r_acc[k]  <= pacc + shifted[W-1:0];
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[NCH-1];
    assign o_res   = r_acc[NCH-1];
    assign o_side  = r_side[NCH-1];

endmodule

// File: rtl/bpim_cfg.sv
// ----------------------------------------------------------------------------
// bpim_cfg
// Configuration registers and a serial sequencer that derives the block
// volume, this rank's offset and its subdomain origin after reset and every write.
// ----------------------------------------------------------------------------
module bpim_cfg #(
    parameter int W     = 42,
    parameter int DIM_W = 15
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic                                                      i_cfg_we,
    input  logic [bpim_pkg::CFG_IDX_W-1:0]                            i_cfg_idx,
    input  logic [bpim_pkg::max_int(DIM_W, bpim_pkg::RANK_W)-1:0]    i_cfg_data,
    output logic [DIM_W-1:0]                                          o_dim_x,
    output logic [DIM_W-1:0]                                          o_dim_y,
    output logic [DIM_W-1:0]                                          o_dim_z,
    output logic [DIM_W-1:0]                                          o_block,
    output logic [bpim_pkg::PROCS_W-1:0]                              o_procs_x,
    output logic [bpim_pkg::PROCS_W-1:0]                              o_procs_y,
    output logic                                                      o_part_ok,
    output logic [W-1:0]                                              o_b3,
    output logic [W-1:0]                                              o_roff,
    output logic [W-1:0]                                              o_rxb,
    output logic [W-1:0]                                              o_ryb,
    output logic [W-1:0]                                              o_rzb,
    output logic                                                      o_busy
);
    import bpim_pkg::*;

    localparam int SEQ_W = max_int(RANK_W, DIM_W);
    localparam int DV_W  = max_int(DIM_W, PROCS_W);
    localparam int CNT_W = $clog2(SEQ_W);

    typedef enum logic [3:0] {
        ST_B2, ST_B3, ST_ROFF, ST_PZ, ST_RX, ST_RY, ST_RZ,
        ST_RXB, ST_RYB, ST_RZB, ST_IDLE
    } t_step;

    t_step              r_step;
    logic               r_run;
    logic [CNT_W-1:0]   r_cnt;

    logic [DIM_W-1:0]   r_dim_x, r_dim_y, r_dim_z, r_block;
    logic [PROCS_W-1:0] r_procs_x, r_procs_y;
    logic [RANK_W-1:0]  r_rank;
    logic               r_part_ok;

    logic [W-1:0]       r_b2, r_b3, r_roff, r_rxb, r_ryb, r_rzb;
    logic [DIM_W-1:0]   r_pz, r_rz;
    logic [PROCS_W-1:0] r_rx, r_ry;
    logic [RANK_W-1:0]  r_rr;

    logic [W-1:0]       r_mc, r_acc;
    logic [SEQ_W-1:0]   r_mp, r_q;
    logic [DV_W-1:0]    r_rem, r_dv;

    logic [W-1:0]       acc_nx;
    logic [DV_W:0]      trial;
    logic               ge;
    logic [DV_W-1:0]    rem_nx;
    logic [SEQ_W-1:0]   q_nx;

    // One shift-add multiply step and one restoring divide step per cycle while a step runs.
    always_comb begin
        acc_nx = r_acc + (r_mp[0] ? r_mc : '0);
        trial  = {r_rem, r_q[SEQ_W-1]};
        ge     = (trial >= {1'b0, r_dv});
        rem_nx = ge ? DV_W'(trial - {1'b0, r_dv}) : trial[DV_W-1:0];
        q_nx   = {r_q[SEQ_W-2:0], ge};
    end

    // Register writes restart the sequencer; otherwise it walks its steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x   <= DIM_W'(1);
            r_dim_y   <= DIM_W'(1);
            r_dim_z   <= DIM_W'(1);
            r_block   <= DIM_W'(1);
            r_procs_x <= PROCS_W'(1);
            r_procs_y <= PROCS_W'(1);
            r_rank    <= '0;
            r_part_ok <= 1'b0;
            r_step    <= ST_B2;
            r_run     <= 1'b0;
            r_cnt     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_DIM_X:   r_dim_x   <= i_cfg_data[DIM_W-1:0];
                REG_DIM_Y:   r_dim_y   <= i_cfg_data[DIM_W-1:0];
                REG_DIM_Z:   r_dim_z   <= i_cfg_data[DIM_W-1:0];
                REG_BLOCK:   r_block   <= i_cfg_data[DIM_W-1:0];
                REG_PROCS_X: r_procs_x <= i_cfg_data[PROCS_W-1:0];
                REG_PROCS_Y: r_procs_y <= i_cfg_data[PROCS_W-1:0];
                REG_RANK:    r_rank    <= i_cfg_data[RANK_W-1:0];
                REG_PART_OK: r_part_ok <= i_cfg_data[0];
                default: ;
            endcase
            r_step <= ST_B2;
            r_run  <= 1'b0;
            r_cnt  <= '0;
        end else if (!r_run) begin
            // Load the operands of the current step.
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= '0;
            case (r_step)
                ST_B2: begin
                    r_mc <= W'(r_block);
                    r_mp <= SEQ_W'(r_block);
                end
                ST_B3: begin
                    r_mc <= r_b2;
                    r_mp <= SEQ_W'(r_block);
                end
                ST_ROFF: begin
                    r_mc <= r_b3;
                    r_mp <= SEQ_W'(r_rank);
                end
                ST_PZ: begin
                    r_q  <= SEQ_W'(r_dim_z);
                    r_dv <= DV_W'(r_block);
                end
                ST_RX: begin
                    r_q  <= SEQ_W'(r_rank);
                    r_dv <= DV_W'(r_procs_x);
                end
                ST_RY: begin
                    r_q  <= SEQ_W'(r_rr);
                    r_dv <= DV_W'(r_procs_y);
                end
                ST_RZ: begin
                    r_q  <= SEQ_W'(r_rr);
                    r_dv <= DV_W'(r_pz);
                end
                ST_RXB: begin
                    r_mc <= W'(r_block);
                    r_mp <= SEQ_W'(r_rx);
                end
                ST_RYB: begin
                    r_mc <= W'(r_block);
                    r_mp <= SEQ_W'(r_ry);
                end
                ST_RZB: begin
                    r_mc <= W'(r_block);
                    r_mp <= SEQ_W'(r_rz);
                end
                default: ;
            endcase
            r_run <= (r_step != ST_IDLE);
        end else begin
            r_acc <= acc_nx;
            r_mc  <= r_mc << 1;
            r_mp  <= r_mp >> 1;
            r_rem <= rem_nx;
            r_q   <= q_nx;
            r_cnt <= r_cnt + CNT_W'(1);
            // Last bit of the step: keep the result and move on.
            if (r_cnt == CNT_W'(SEQ_W - 1)) begin
                r_run <= 1'b0;
                case (r_step)
                    ST_B2: begin
                        r_b2   <= acc_nx;
                        r_step <= ST_B3;
                    end
                    ST_B3: begin
                        r_b3   <= acc_nx;
                        r_step <= ST_ROFF;
                    end
                    ST_ROFF: begin
                        r_roff <= acc_nx;
                        r_step <= ST_PZ;
                    end
                    ST_PZ: begin
                        r_pz   <= DIM_W'(q_nx);
                        r_step <= ST_RX;
                    end
                    ST_RX: begin
                        r_rx   <= PROCS_W'(rem_nx);
                        r_rr   <= RANK_W'(q_nx);
                        r_step <= ST_RY;
                    end
                    ST_RY: begin
                        r_ry   <= PROCS_W'(rem_nx);
                        r_rr   <= RANK_W'(q_nx);
                        r_step <= ST_RZ;
                    end
                    ST_RZ: begin
                        // With no whole block along z the rank sits at z = 0.
                        r_rz   <= (r_pz == '0) ? '0 : DIM_W'(rem_nx);
                        r_step <= ST_RXB;
                    end
                    ST_RXB: begin
                        r_rxb  <= acc_nx;
                        r_step <= ST_RYB;
                    end
                    ST_RYB: begin
                        r_ryb  <= acc_nx;
                        r_step <= ST_RZB;
                    end
                    ST_RZB: begin
                        r_rzb  <= acc_nx;
                        r_step <= ST_IDLE;
                    end
                    default: r_step <= ST_IDLE;
                endcase
            end
        end
    end

    assign o_dim_x   = r_dim_x;
    assign o_dim_y   = r_dim_y;
    assign o_dim_z   = r_dim_z;
    assign o_block   = r_block;
    assign o_procs_x = r_procs_x;
    assign o_procs_y = r_procs_y;
    assign o_part_ok = r_part_ok;
    assign o_b3      = r_b3;
    assign o_roff    = r_roff;
    assign o_rxb     = r_rxb;
    assign o_ryb     = r_ryb;
    assign o_rzb     = r_rzb;
    assign o_busy    = (r_step != ST_IDLE);

endmodule
